// File: hdl/pfx_eval_pkg.sv
package pfx_eval_pkg;

	// Stack geometry
	localparam int STACK_DEPTH = 64;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [2:0]        status_t;

	// Expression characters (ASCII)
	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_NINE = 8'h39;
	localparam logic [7:0] SYM_ADD  = 8'h2B;
	localparam logic [7:0] SYM_SUB  = 8'h2D;
	localparam logic [7:0] SYM_MUL  = 8'h2A;
	localparam logic [7:0] SYM_DIV  = 8'h2F;

	// Result status codes
	localparam status_t ST_OK   = 3'd0;
	localparam status_t ST_FEW  = 3'd1;
	localparam status_t ST_LEFT = 3'd2;
	localparam status_t ST_DIV0 = 3'd3;
	localparam status_t ST_OVER = 3'd4;

endpackage

// File: hdl/postfix_expression_evaluator.sv
// Postfix (RPN) evaluator: one ASCII character per input transaction, tlast on the final
// character. Digits push 0..9, '+' '-' '*' '/' pop two operands and push the 32-bit wrapped
// result (quotient truncates toward zero); other characters are ignored, and after the first
// error the rest of the expression is skipped. The transaction carrying tlast yields exactly
// one result: tdata is the top of stack (0 if empty or on error), tuser the status
// (0 ok, 1 too few operands, 2 operands left over, 3 divide by zero, 4 stack overflow).
// The stack holds 64 entries: the top lives in a register, the rest in a synchronous RAM
// with one write and one read port, the entry under the top read ahead into a register. Each
// character passes through accept and decode; a valid '/' then also runs a 32-step radix-2
// divider; the final character then loads the output register, after any wait while a
// previous result is still not taken.
module postfix_expression_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tlast,   // last_symbol
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] value
	output logic [2:0]  m_axis_tuser    // [2:0] status
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_DIV    = 3'd2;
	localparam logic [2:0] S_FIN    = 3'd3;

	logic [2:0]               state_q;
	logic [7:0]               sym_q;
	logic                     last_q;
	pfx_eval_pkg::count_t     count_q;
	pfx_eval_pkg::status_t    err_q;
	pfx_eval_pkg::word_t      top_q;

	// stack RAM (entries below the top)
	pfx_eval_pkg::word_t      mem [pfx_eval_pkg::STACK_DEPTH];
	pfx_eval_pkg::word_t      rd_data_q;
	pfx_eval_pkg::ptr_t       mem_raddr;
	pfx_eval_pkg::ptr_t       mem_waddr;
	logic                     mem_we;

	// divider
	pfx_eval_pkg::word_t      rem_q;
	pfx_eval_pkg::word_t      quo_q;
	pfx_eval_pkg::word_t      dvs_q;
	logic                     neg_q;
	logic [4:0]               div_cnt_q;
	logic [32:0]              div_trial;
	pfx_eval_pkg::word_t      rem_nx;
	pfx_eval_pkg::word_t      quo_nx;

	// output register
	logic                     m_valid_q;
	pfx_eval_pkg::word_t      m_value_q;
	pfx_eval_pkg::status_t    m_status_q;

	// decode helpers
	logic                     is_digit;
	logic                     is_op;
	logic                     div_go;
	pfx_eval_pkg::count_t     count_m1;
	pfx_eval_pkg::count_t     count_m2;
	pfx_eval_pkg::word_t      opa;
	pfx_eval_pkg::word_t      opb;
	pfx_eval_pkg::word_t      mag_a;
	pfx_eval_pkg::word_t      mag_b;
	pfx_eval_pkg::word_t      product;
	logic                     out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_value_q;
	assign m_axis_tuser  = m_status_q;

	assign is_digit = (sym_q inside {[pfx_eval_pkg::SYM_ZERO:pfx_eval_pkg::SYM_NINE]});
	assign is_op    = (sym_q inside {pfx_eval_pkg::SYM_ADD, pfx_eval_pkg::SYM_SUB,
		pfx_eval_pkg::SYM_MUL, pfx_eval_pkg::SYM_DIV});
	assign count_m1 = count_q - pfx_eval_pkg::CNT_W'(1);
	assign count_m2 = count_q - pfx_eval_pkg::CNT_W'(2);
	assign opa      = rd_data_q;
	assign opb      = top_q;
	assign mag_a    = opa[31] ? (32'd0 - opa) : opa;
	assign mag_b    = opb[31] ? (32'd0 - opb) : opb;
	assign product  = opa * opb;
	assign out_free = !m_valid_q || m_axis_tready;

	// a valid divide leaves decode for the divider
	assign div_go   = (err_q == pfx_eval_pkg::ST_OK) && (sym_q == pfx_eval_pkg::SYM_DIV)
		&& (count_q >= pfx_eval_pkg::CNT_W'(2)) && (opb != '0);

	// RAM addressing: read the entry under the top, push spills the old top
	assign mem_raddr = count_m2[pfx_eval_pkg::PTR_W-1:0];
	assign mem_waddr = count_m1[pfx_eval_pkg::PTR_W-1:0];
	assign mem_we    = (state_q == S_DECODE) && (err_q == pfx_eval_pkg::ST_OK) && is_digit
		&& (count_q < pfx_eval_pkg::CNT_W'(pfx_eval_pkg::STACK_DEPTH))
		&& (count_q != '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= top_q;
		end
		rd_data_q <= mem[mem_raddr];
	end

	// one restoring divide step on magnitudes
	always_comb begin
		div_trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
		if (!div_trial[32]) begin
			rem_nx = div_trial[31:0];
			quo_nx = {quo_q[30:0], 1'b1};
		end else begin
			rem_nx = {rem_q[30:0], quo_q[31]};
			quo_nx = {quo_q[30:0], 1'b0};
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == S_DECODE) begin
			rem_q     <= '0;
			quo_q     <= mag_a;
			dvs_q     <= mag_b;
			neg_q     <= opa[31] ^ opb[31];
			div_cnt_q <= '0;
		end else if (state_q == S_DIV) begin
			rem_q     <= rem_nx;
			quo_q     <= quo_nx;
			div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	// input transaction capture
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sym_q  <= s_axis_tdata;
			last_q <= s_axis_tlast;
		end
	end

	// top-of-stack register
	always_ff @(posedge clk) begin
		if (state_q == S_DECODE && err_q == pfx_eval_pkg::ST_OK) begin
			if (is_digit) begin
				if (count_q < pfx_eval_pkg::CNT_W'(pfx_eval_pkg::STACK_DEPTH)) begin
					top_q <= {24'd0, sym_q - pfx_eval_pkg::SYM_ZERO};
				end
			end else if (is_op && count_q >= pfx_eval_pkg::CNT_W'(2)) begin
				case (sym_q)
					pfx_eval_pkg::SYM_ADD: top_q <= opa + opb;
					pfx_eval_pkg::SYM_SUB: top_q <= opa - opb;
					pfx_eval_pkg::SYM_MUL: top_q <= product;
					default: ;
				endcase
			end
		end else if (state_q == S_DIV && div_cnt_q == 5'd31) begin
			top_q <= neg_q ? (32'd0 - quo_nx) : quo_nx;
		end
	end

	// control: sequencer, stack count, error latch, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			err_q      <= pfx_eval_pkg::ST_OK;
			m_valid_q  <= 1'b0;
			m_value_q  <= '0;
			m_status_q <= pfx_eval_pkg::ST_OK;
		end else begin
			// in S_FIN the load below owns the valid flag
			if (m_valid_q && m_axis_tready && state_q != S_FIN) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (div_go) begin
						state_q <= S_DIV;
					end else begin
						state_q <= last_q ? S_FIN : S_IDLE;
					end
					if (err_q == pfx_eval_pkg::ST_OK) begin
						if (is_digit) begin
							if (count_q < pfx_eval_pkg::CNT_W'(pfx_eval_pkg::STACK_DEPTH)) begin
								count_q <= count_q + pfx_eval_pkg::CNT_W'(1);
							end else begin
								err_q <= pfx_eval_pkg::ST_OVER;
							end
						end else if (is_op) begin
							if (count_q < pfx_eval_pkg::CNT_W'(2)) begin
								err_q <= pfx_eval_pkg::ST_FEW;
							end else if (sym_q == pfx_eval_pkg::SYM_DIV) begin
								if (opb == '0) begin
									err_q <= pfx_eval_pkg::ST_DIV0;
								end else begin
									count_q <= count_m1;
								end
							end else begin
								count_q <= count_m1;
							end
						end
					end
				end
				S_DIV: begin
					if (div_cnt_q == 5'd31) begin
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					// load result once the output register is free
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (err_q == pfx_eval_pkg::ST_OK
							&& count_q == pfx_eval_pkg::CNT_W'(1)) begin
							m_value_q <= top_q;
						end else begin
							m_value_q <= '0;
						end
						if (err_q != pfx_eval_pkg::ST_OK) begin
							m_status_q <= err_q;
						end else if (count_q > pfx_eval_pkg::CNT_W'(1)) begin
							m_status_q <= pfx_eval_pkg::ST_LEFT;
						end else begin
							m_status_q <= pfx_eval_pkg::ST_OK;
						end
						count_q <= '0;
						err_q   <= pfx_eval_pkg::ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SYMBOL_TARGET = 1400;
	localparam int IDLE_LIMIT    = 3000;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		pfx_eval_pkg::word_t   value;
		pfx_eval_pkg::status_t status;
	} expr_result_t;

	// Expression evaluator model plus queue of expected results
	class expr_scoreboard;
		pfx_eval_pkg::word_t   stack_mem [pfx_eval_pkg::STACK_DEPTH];
		int unsigned           depth;
		pfx_eval_pkg::status_t latched;
		expr_result_t          expected_q [$];
		int unsigned           mismatches;
		int unsigned           checked;
		int unsigned           status_tally [5];

		function new();
			depth   = 0;
			latched = pfx_eval_pkg::ST_OK;
		endfunction

		// signed quotient, truncated toward zero, wraps on min / -1
		function pfx_eval_pkg::word_t quotient_trunc(pfx_eval_pkg::word_t lhs,
			pfx_eval_pkg::word_t rhs);
			pfx_eval_pkg::word_t mag_l, mag_r, q;
			mag_l = lhs[pfx_eval_pkg::DATA_W-1] ? pfx_eval_pkg::word_t'(0) - lhs : lhs;
			mag_r = rhs[pfx_eval_pkg::DATA_W-1] ? pfx_eval_pkg::word_t'(0) - rhs : rhs;
			q = mag_l / mag_r;
			return (lhs[pfx_eval_pkg::DATA_W-1] ^ rhs[pfx_eval_pkg::DATA_W-1]) ?
				pfx_eval_pkg::word_t'(0) - q : q;
		endfunction

		function void apply_symbol(logic [7:0] sym);
			pfx_eval_pkg::word_t lhs, rhs, res;
			if (sym >= pfx_eval_pkg::SYM_ZERO && sym <= pfx_eval_pkg::SYM_NINE) begin
				if (depth >= pfx_eval_pkg::STACK_DEPTH) begin
					latched = pfx_eval_pkg::ST_OVER;
				end else begin
					stack_mem[depth] = pfx_eval_pkg::word_t'(sym - pfx_eval_pkg::SYM_ZERO);
					depth++;
				end
				return;
			end
			if (!(sym inside {pfx_eval_pkg::SYM_ADD, pfx_eval_pkg::SYM_SUB,
				pfx_eval_pkg::SYM_MUL, pfx_eval_pkg::SYM_DIV}))
				return;
			if (depth < 2) begin
				latched = pfx_eval_pkg::ST_FEW;
				return;
			end
			rhs = stack_mem[depth-1];
			lhs = stack_mem[depth-2];
			case (sym)
				pfx_eval_pkg::SYM_ADD: res = lhs + rhs;
				pfx_eval_pkg::SYM_SUB: res = lhs - rhs;
				pfx_eval_pkg::SYM_MUL: res = lhs * rhs;
				default: begin
					// zero divisor leaves the stack alone
					if (rhs == '0) begin
						latched = pfx_eval_pkg::ST_DIV0;
						return;
					end
					res = quotient_trunc(lhs, rhs);
				end
			endcase
			depth--;
			stack_mem[depth-1] = res;
		endfunction

		// accepted input transaction
		function void note_symbol(logic [7:0] sym, logic is_last);
			expr_result_t r;
			if (latched == pfx_eval_pkg::ST_OK)
				apply_symbol(sym);
			if (!is_last)
				return;
			r.value  = '0;
			r.status = latched;
			if (latched == pfx_eval_pkg::ST_OK) begin
				if (depth > 1)
					r.status = pfx_eval_pkg::ST_LEFT;
				else if (depth == 1)
					r.value = stack_mem[0];
			end
			expected_q.push_back(r);
			status_tally[r.status]++;
			depth   = 0;
			latched = pfx_eval_pkg::ST_OK;
		endfunction

		// accepted output transaction
		function void check_result(pfx_eval_pkg::word_t value, pfx_eval_pkg::status_t status);
			expr_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %0d: result value %0d status %0d with nothing expected",
						mismatches, $signed(value), status);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (value !== want.value || status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %0d: expected value %0d status %0d, got value %0d status %0d",
						mismatches, $signed(want.value), want.status, $signed(value), status);
			end
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	expr_scoreboard sb = new();

	bit          quiet_phase = 1'b0;
	int          ready_hold  = 0;
	int          idle_cycles = 0;
	int unsigned active_syms = 0;
	int unsigned sent_syms   = 0;
	int unsigned expr_count  = 0;
	logic [7:0]  expr_chars [$];

	postfix_expression_evaluator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones; none in quiet phases
	function automatic int pick_gap();
		int r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit is_active(logic [7:0] sym);
		return (sym >= pfx_eval_pkg::SYM_ZERO && sym <= pfx_eval_pkg::SYM_NINE) ||
			(sym inside {pfx_eval_pkg::SYM_ADD, pfx_eval_pkg::SYM_SUB,
				pfx_eval_pkg::SYM_MUL, pfx_eval_pkg::SYM_DIV});
	endfunction

	function automatic logic [7:0] rand_digit();
		return pfx_eval_pkg::SYM_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(0, 3))
			0:       return pfx_eval_pkg::SYM_ADD;
			1:       return pfx_eval_pkg::SYM_SUB;
			2:       return pfx_eval_pkg::SYM_MUL;
			default: return pfx_eval_pkg::SYM_DIV;
		endcase
	endfunction

	function automatic logic [7:0] rand_ignored();
		logic [7:0] s;
		do begin
			s = 8'($urandom_range(0, 255));
		end while (is_active(s));
		return s;
	endfunction

	function automatic void add_sym(logic [7:0] s);
		expr_chars.push_back(s);
	endfunction

	function automatic void add_digit(int n);
		expr_chars.push_back(pfx_eval_pkg::SYM_ZERO + 8'(n));
	endfunction

	// valid postfix with random digits and operators, a few ignored characters
	function automatic void build_wellformed(int max_operands);
		int depth, pushed, target;
		depth  = 0;
		pushed = 0;
		target = $urandom_range(1, max_operands);
		while (pushed < target || depth > 1) begin
			if ($urandom_range(0, 11) == 0)
				add_sym(rand_ignored());
			if (pushed < target && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				add_sym(rand_digit());
				depth++;
				pushed++;
			end else begin
				add_sym(rand_op());
				depth--;
			end
		end
		if ($urandom_range(0, 9) == 0)
			add_sym(rand_ignored());
	endfunction

	function automatic void build_broken();
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 2))
				0:       add_sym(rand_digit());
				1:       add_sym(rand_op());
				default: add_sym(rand_ignored());
			endcase
		end
	endfunction

	// long chains of nonzero operands so that products wrap
	function automatic void build_wide_product();
		add_digit($urandom_range(1, 9));
		repeat ($urandom_range(6, 18)) begin
			add_digit($urandom_range(1, 9));
			case ($urandom_range(0, 3))
				0, 1:    add_sym(pfx_eval_pkg::SYM_MUL);
				2:       add_sym(pfx_eval_pkg::SYM_SUB);
				default: add_sym(pfx_eval_pkg::SYM_ADD);
			endcase
		end
		if ($urandom_range(0, 1) == 1) begin
			add_digit($urandom_range(1, 9));
			add_sym(pfx_eval_pkg::SYM_DIV);
		end
	endfunction

	// fill the stack exactly, or push past it
	function automatic void build_overflow();
		int n;
		n = pfx_eval_pkg::STACK_DEPTH + $urandom_range(0, 2);
		repeat (n) add_sym(rand_digit());
		if (n == pfx_eval_pkg::STACK_DEPTH && $urandom_range(0, 1) == 1)
			repeat (pfx_eval_pkg::STACK_DEPTH - 1) add_sym(rand_op());
		else
			repeat ($urandom_range(0, 3)) add_sym(rand_op());
	endfunction

	// 2 * 8^10 wraps to the most negative word, then combine with -1
	function automatic void build_most_negative();
		add_digit(2);
		repeat (10) begin
			add_digit(8);
			add_sym(pfx_eval_pkg::SYM_MUL);
		end
		add_digit(0);
		add_digit(1);
		add_sym(pfx_eval_pkg::SYM_SUB);
		case ($urandom_range(0, 3))
			0:       add_sym(pfx_eval_pkg::SYM_MUL);
			1:       add_sym(pfx_eval_pkg::SYM_ADD);
			default: add_sym(pfx_eval_pkg::SYM_DIV);
		endcase
	endfunction

	// one input transaction, held until accepted
	task automatic send_symbol(input logic [7:0] sym, input logic is_last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent_syms++;
		if (is_active(sym))
			active_syms++;
	endtask

	task automatic play_expr();
		foreach (expr_chars[i])
			send_symbol(expr_chars[i], i == expr_chars.size() - 1);
		expr_chars.delete();
		expr_count++;
	endtask

	// result side backpressure
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			m_axis_tready <= 1'b0;
			ready_hold    <= ready_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			ready_hold    <= pick_gap();
		end
	end

	// monitor both interfaces
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_symbol(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		int unsigned failures;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single digit, empty, basic operations
		add_digit(9); play_expr();
		add_sym(8'hFF); play_expr();
		add_digit(0); play_expr();
		add_digit(3); add_digit(4); add_sym(pfx_eval_pkg::SYM_ADD); play_expr();
		add_digit(3); add_digit(5); add_sym(pfx_eval_pkg::SYM_SUB); play_expr();
		add_digit(7); add_digit(8); add_sym(pfx_eval_pkg::SYM_MUL); play_expr();
		add_digit(9); add_digit(3); add_sym(pfx_eval_pkg::SYM_DIV); play_expr();
		// negative quotient truncates toward zero
		add_digit(0); add_digit(7); add_sym(pfx_eval_pkg::SYM_SUB); add_digit(2);
		add_sym(pfx_eval_pkg::SYM_DIV);
		play_expr();
		// too few operands, operands left over
		add_digit(5); add_sym(pfx_eval_pkg::SYM_ADD); play_expr();
		add_sym(pfx_eval_pkg::SYM_DIV); play_expr();
		add_digit(1); add_digit(2); play_expr();
		// divide by zero, rest of expression ignored
		add_digit(5); add_digit(0); add_sym(pfx_eval_pkg::SYM_DIV); add_digit(3);
		add_sym(pfx_eval_pkg::SYM_ADD);
		play_expr();
		add_sym(8'h00); play_expr();

		// random expressions
		while (sent_syms < SYMBOL_TARGET) begin
			quiet_phase <= ($urandom_range(0, 6) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 56)
				build_wellformed(6);
			else if (pick < 68)
				build_wellformed(30);
			else if (pick < 70)
				build_wellformed(70);
			else if (pick < 82)
				build_broken();
			else if (pick < 89)
				build_wide_product();
			else if (pick < 91)
				build_overflow();
			else if (pick < 95)
				build_most_negative();
			else
				repeat ($urandom_range(1, 4)) add_sym(rand_ignored());
			play_expr();
		end
		s_axis_tvalid <= 1'b0;

		// drain outstanding results
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		failures = sb.mismatches + sb.expected_q.size();
		$display("Ran %0d expressions, %0d symbols (%0d digit/operator), %0d results checked",
			expr_count, sent_syms, active_syms, sb.checked);
		$display("Status mix: ok %0d, too few %0d, left over %0d, div by zero %0d, overflow %0d",
			sb.status_tally[pfx_eval_pkg::ST_OK], sb.status_tally[pfx_eval_pkg::ST_FEW],
			sb.status_tally[pfx_eval_pkg::ST_LEFT], sb.status_tally[pfx_eval_pkg::ST_DIV0],
			sb.status_tally[pfx_eval_pkg::ST_OVER]);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results never arrived",
				sb.mismatches, sb.expected_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/pfx_eval_pkg.sv
hdl/postfix_expression_evaluator.sv
bench/tb_top.sv
